// File: rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion, also checked during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

// File: rtl/core/sbk_pkg.sv
// Package: constants, codes and types of the selectable-key record sorter.
`timescale 1ns / 1ps
`default_nettype none
package sbk_pkg;
   localparam int CAPACITY = 16;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int ROLL_W   = 16;
   localparam int NAME_W   = 64;
   localparam int SCORE_W  = 10;
   localparam int KEYSEL_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 2;

   localparam logic [KEYSEL_W-1:0] KEY_ROLL  = 2'd0;
   localparam logic [KEYSEL_W-1:0] KEY_NAME  = 2'd1;
   localparam logic [KEYSEL_W-1:0] KEY_SCORE = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_SORT_KEY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DESCENDING = 2'd1;

   typedef enum logic [1:0] {ST_IDLE, ST_SORT, ST_EMIT} state_type;

   typedef struct packed {
      logic                load;
      logic                sort;
      logic                phase;
      logic                shift;
      logic [CNT_W-1:0]    count;
      logic [KEYSEL_W-1:0] key_sel;
      logic                descending;
   } cmd_type;
endpackage
`default_nettype wire

// File: rtl/core/record_sort_by_selectable_key.sv
// Top level: stable record sorter with a selectable key and direction.
// Loading: one record per cycle, accepted while busy is low.
// The record with is_last starts CAPACITY (16) odd-even passes, one a cycle,
// then the stored records leave one per cycle on rsp_valid.
// Busy stays high from sort to last result.
// Reset (synchronous, active high) empties the store and sets both registers to zero.
`timescale 1ns / 1ps
`default_nettype none
module record_sort_by_selectable_key (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [sbk_pkg::ROLL_W-1:0]    req_roll_number,
   input  wire logic [sbk_pkg::NAME_W-1:0]    req_packed_name,
   input  wire logic [sbk_pkg::SCORE_W-1:0]   req_score_hundredths,
   input  wire logic                          req_is_last,
   output logic                               rsp_valid,
   output logic [sbk_pkg::ROLL_W-1:0]         rsp_out_roll,
   output logic [sbk_pkg::NAME_W-1:0]         rsp_out_name,
   output logic [sbk_pkg::SCORE_W-1:0]        rsp_out_score,
   output logic                               rsp_out_last,
   output logic                               rsp_overflowed,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [sbk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sbk_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import sbk_pkg::*;

   cmd_type cmd;

   // Control: count the load, run the passes, pace the transfer of results.
   sbk_controller u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .is_last        (req_is_last),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .busy           (busy),
      .csr_ready      (csr_ready),
      .rsp_valid      (rsp_valid),
      .rsp_last       (rsp_out_last),
      .rsp_overflowed (rsp_overflowed),
      .cmd            (cmd)
   );

   // Storage: hold records, exchange neighbors, shift the head out.
   sbk_datapath u_dp (
      .clock      (clock),
      .cmd        (cmd),
      .in_roll    (req_roll_number),
      .in_name    (req_packed_name),
      .in_score   (req_score_hundredths),
      .head_roll  (rsp_out_roll),
      .head_name  (rsp_out_name),
      .head_score (rsp_out_score)
   );
endmodule
`default_nettype wire

// File: rtl/core/sbk_datapath.sv
// Datapath: record registers, odd-even transposition sort lanes, shift-out.
`timescale 1ns / 1ps
`default_nettype none
module sbk_datapath (
   input  wire logic                     clock,
   input  wire sbk_pkg::cmd_type         cmd,
   input  wire logic [sbk_pkg::ROLL_W-1:0]  in_roll,
   input  wire logic [sbk_pkg::NAME_W-1:0]  in_name,
   input  wire logic [sbk_pkg::SCORE_W-1:0] in_score,
   output logic [sbk_pkg::ROLL_W-1:0]    head_roll,
   output logic [sbk_pkg::NAME_W-1:0]    head_name,
   output logic [sbk_pkg::SCORE_W-1:0]   head_score
);
   import sbk_pkg::*;

   logic [ROLL_W-1:0]  roll_ff  [CAPACITY];
   logic [NAME_W-1:0]  name_ff  [CAPACITY];
   logic [SCORE_W-1:0] score_ff [CAPACITY];
   logic [ROLL_W-1:0]  roll_in  [CAPACITY];
   logic [NAME_W-1:0]  name_in  [CAPACITY];
   logic [SCORE_W-1:0] score_in [CAPACITY];
   logic [NAME_W-1:0]  key      [CAPACITY];
   logic [CAPACITY-1:0] swap;

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         case (cmd.key_sel)
            KEY_ROLL:  key[i] = {{(NAME_W-ROLL_W){1'b0}}, roll_ff[i]};
            KEY_NAME:  key[i] = name_ff[i];
            KEY_SCORE: key[i] = {{(NAME_W-SCORE_W){1'b0}}, score_ff[i]};
            default:   key[i] = '0;
         endcase
      end
      // swap[i]: pair (i, i+1) of this phase exchanges when the upper one
      // strictly goes first; equal keys never move, so the sort is stable
      for (int i = 0; i < CAPACITY; i++) begin
         swap[i] = 1'b0;
         if (i < CAPACITY - 1) begin
            if ((i % 2) == int'(cmd.phase) && (CNT_W'(i + 1) < cmd.count))
               swap[i] = cmd.descending ? (key[i+1] > key[i]) : (key[i+1] < key[i]);
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         roll_in[i]  = roll_ff[i];
         name_in[i]  = name_ff[i];
         score_in[i] = score_ff[i];
         if (cmd.load) begin
            if (CNT_W'(i) == cmd.count) begin
               roll_in[i]  = in_roll;
               name_in[i]  = in_name;
               score_in[i] = in_score;
            end
         end else if (cmd.sort) begin
            if (swap[i]) begin
               roll_in[i]  = roll_ff[i+1 < CAPACITY ? i+1 : i];
               name_in[i]  = name_ff[i+1 < CAPACITY ? i+1 : i];
               score_in[i] = score_ff[i+1 < CAPACITY ? i+1 : i];
            end else if (i > 0 && swap[i > 0 ? i-1 : 0]) begin
               roll_in[i]  = roll_ff[i > 0 ? i-1 : 0];
               name_in[i]  = name_ff[i > 0 ? i-1 : 0];
               score_in[i] = score_ff[i > 0 ? i-1 : 0];
            end
         end else if (cmd.shift) begin
            if (i < CAPACITY - 1) begin
               roll_in[i]  = roll_ff[i+1 < CAPACITY ? i+1 : i];
               name_in[i]  = name_ff[i+1 < CAPACITY ? i+1 : i];
               score_in[i] = score_ff[i+1 < CAPACITY ? i+1 : i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         roll_ff[i]  <= roll_in[i];
         name_ff[i]  <= name_in[i];
         score_ff[i] <= score_in[i];
      end
   end

   assign head_roll  = roll_ff[0];
   assign head_name  = name_ff[0];
   assign head_score = score_ff[0];
endmodule
`default_nettype wire

// File: rtl/core/sbk_controller.sv
// Controller: load count, overflow flag, sort passes and emit sequencing.
`timescale 1ns / 1ps
`default_nettype none
module sbk_controller (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic                          is_last,
   input  wire logic                          csr_valid,
   input  wire logic [sbk_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sbk_pkg::CSR_DAT_W-1:0] csr_wdata,
   output logic                               busy,
   output logic                               csr_ready,
   output logic                               rsp_valid,
   output logic                               rsp_last,
   output logic                               rsp_overflowed,
   output sbk_pkg::cmd_type                   cmd
);
   import sbk_pkg::*;

   state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pass_ff, pass_in;
   logic phase_ff, phase_in;
   logic ovf_ff, ovf_in;
   logic [KEYSEL_W-1:0] key_ff;
   logic desc_ff;
   logic accept, room;

   assign accept = start && (state_ff == ST_IDLE);
   assign room   = count_ff < CNT_W'(CAPACITY);

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff  <= KEY_ROLL;
         desc_ff <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_SORT_KEY:   key_ff  <= csr_wdata[KEYSEL_W-1:0];
            REG_DESCENDING: desc_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept && is_last) state_in = ST_SORT;
         ST_SORT: if (pass_ff == CNT_W'(1)) state_in = ST_EMIT;
         ST_EMIT: if (count_ff == CNT_W'(1)) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      pass_in  = pass_ff;
      phase_in = phase_ff;
      ovf_in   = ovf_ff;
      cmd      = '0;
      cmd.count      = count_ff;
      cmd.key_sel    = key_ff;
      cmd.descending = desc_ff;
      cmd.phase      = phase_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (room) begin
                  cmd.load = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               pass_in  = CNT_W'(CAPACITY);
               phase_in = 1'b0;
            end
         end
         ST_SORT: begin
            cmd.sort = 1'b1;
            pass_in  = pass_ff - CNT_W'(1);
            phase_in = ~phase_ff;
         end
         ST_EMIT: begin
            cmd.shift = 1'b1;
            count_in  = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) ovf_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pass_ff  <= '0;
         phase_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pass_ff  <= pass_in;
         phase_ff <= phase_in;
         ovf_ff   <= ovf_in;
      end
   end

   assign busy           = state_ff != ST_IDLE;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = state_ff == ST_EMIT;
   assign rsp_last       = rsp_valid && (count_ff == CNT_W'(1));
   assign rsp_overflowed = ovf_ff;
endmodule
`default_nettype wire

// File: rtl/core/sbk_checker.sv
// Port-level checker for the record sorter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sbk_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic req_is_last,
   input wire logic rsp_valid,
   input wire logic rsp_out_last
);
   `ASSERT_CLK_RST(a_rsp_busy, clock, reset, rsp_valid |-> busy, "result while idle")
   `ASSERT_CLK_RST(a_last_busy, clock, reset, (start && !busy && req_is_last) |=> busy, "no sort")
   `ASSERT_CLK_RST(a_last_valid, clock, reset, rsp_out_last |-> rsp_valid, "stray last")
   `ASSERT_CLK_RST(a_run, clock, reset, (rsp_valid && !rsp_out_last) |=> rsp_valid, "gap")
   `ASSERT_CLK(a_reset, clock, reset |=> !busy, "busy after reset")
endmodule

bind record_sort_by_selectable_key sbk_checker u_sbk_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_is_last  (req_is_last),
   .rsp_valid    (rsp_valid),
   .rsp_out_last (rsp_out_last)
);
`default_nettype wire

// File: tb/record_sort_by_selectable_key_test.sv
// Testbench for the selectable-key stable record sorter: directed table plus random sets.
`timescale 1ns / 1ps
`default_nettype none
module record_sort_by_selectable_key_test;
   import sbk_pkg::*;

   localparam int LIMIT      = 20000;
   localparam int TAIL_WAIT  = 60;
   localparam int RAND_ITEMS = 220;

   // One record as it travels into and out of the sorter.
   typedef struct {
      logic [ROLL_W-1:0]  roll;
      logic [NAME_W-1:0]  name;
      logic [SCORE_W-1:0] score;
      logic               last;
      logic               ovf;
   } record_t;

   // One row of the directed table; chk marks a typed-in expectation.
   typedef struct {
      logic [ROLL_W-1:0]  roll;
      logic [NAME_W-1:0]  name;
      logic [SCORE_W-1:0] score;
      logic               last;
      bit                 chk;
      logic [ROLL_W-1:0]  x_roll;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [ROLL_W-1:0]  req_roll_number = '0;
   logic [NAME_W-1:0]  req_packed_name = '0;
   logic [SCORE_W-1:0] req_score_hundredths = '0;
   logic req_is_last = 1'b0;
   logic rsp_valid;
   logic [ROLL_W-1:0]  rsp_out_roll;
   logic [NAME_W-1:0]  rsp_out_name;
   logic [SCORE_W-1:0] rsp_out_score;
   logic rsp_out_last, rsp_overflowed;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   record_sort_by_selectable_key dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow of the sorter: registers, stored set, queue of records due out.
   logic [KEYSEL_W-1:0] key_sel_sh = KEY_ROLL;
   logic                desc_sh    = 1'b0;
   record_t             held[$];
   bit                  dropped;
   record_t             due_out[$];
   int                  n_errors;
   int                  idle_cycles;
   int                  typed_roll[$];

   function automatic logic [NAME_W-1:0] key_value(record_t r);
      case (key_sel_sh)
         KEY_ROLL:  return NAME_W'(r.roll);
         KEY_NAME:  return r.name;
         KEY_SCORE: return NAME_W'(r.score);
         default:   return '0;
      endcase
   endfunction

   // Store one accepted record; on the last one, sort stably and queue the set.
   task automatic sort_and_queue(record_t in);
      record_t tmp, cur;
      int j;
      if (held.size() < CAPACITY) held.push_back(in);
      else dropped = 1'b1;
      if (!in.last) return;
      for (int i = 1; i < held.size(); i++) begin
         cur = held[i];
         j = i;
         while (j > 0 && (desc_sh ? key_value(cur) > key_value(held[j-1])
                                  : key_value(cur) < key_value(held[j-1]))) begin
            held[j] = held[j-1];
            j--;
         end
         held[j] = cur;
      end
      foreach (held[i]) begin
         tmp = held[i];
         tmp.last = (i == held.size() - 1);
         tmp.ovf  = dropped;
         due_out.push_back(tmp);
      end
      held.delete();
      dropped = 1'b0;
   endtask

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      n_errors++;
   endtask

   // Check every result in the cycle it is shown; the receiver never stalls.
   always @(posedge clock) begin
      record_t e;
      if (!reset && rsp_valid) begin
         if (due_out.size() == 0) begin
            report("unexpected result roll", rsp_out_roll, 0);
         end else begin
            e = due_out.pop_front();
            if (rsp_out_roll !== e.roll) report("roll", rsp_out_roll, e.roll);
            if (rsp_out_name !== e.name) report("name", rsp_out_name, e.name);
            if (rsp_out_score !== e.score) report("score", rsp_out_score, e.score);
            if (rsp_out_last !== e.last) report("last", rsp_out_last, e.last);
            if (rsp_overflowed !== e.ovf) report("overflowed", rsp_overflowed, e.ovf);
            if (typed_roll.size() > 0) begin
               if (rsp_out_roll !== typed_roll[0])
                  report("typed roll", rsp_out_roll, typed_roll[0]);
               void'(typed_roll.pop_front());
            end
         end
      end
   end

   // Watchdog: count cycles with no transfer anywhere.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
         $display("record_sort_by_selectable_key test failed");
         $finish;
      end
   end

   // Write one register between sets, with the sorter idle.
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_SORT_KEY) key_sel_sh = val;
      else if (idx == REG_DESCENDING) desc_sh = val[0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Drain all expected results, then let the sorter settle.
   task automatic drain;
      while (due_out.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   // Offer one record and hold it until the transfer; records come in bursts between gaps.
   int burst_left;
   task automatic send(record_t r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      start <= 1'b1;
      req_roll_number <= r.roll;
      req_packed_name <= r.name;
      req_score_hundredths <= r.score;
      req_is_last <= r.last;
      do @(posedge clock); while (busy);
      sort_and_queue(r);
      burst_left--;
   endtask

   function automatic logic [NAME_W-1:0] rand_name();
      logic [NAME_W-1:0] n;
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      n = '0;
      for (int b = 0; b < $urandom_range(1, 8); b++)
         n[63 - 8*b -: 8] = 8'($urandom_range(8'h41, 8'h44));
      return n;
   endfunction

   row_t table_rows[$];
   record_t r;
   int n_set;

   initial begin
      n_errors = 0;
      idle_cycles = 0;
      burst_left = 0;
      dropped = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: single record after reset, extremes, then a full store overflow.
      table_rows.push_back('{16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 10'h3FF, 1'b1, 1, 16'hFFFF});
      table_rows.push_back('{16'd5, 64'd0, 10'd0, 1'b0, 1, 16'd0});
      table_rows.push_back('{16'd0, 64'h4100_0000_0000_0000, 10'd1000, 1'b0, 1, 16'd5});
      table_rows.push_back('{16'd5, 64'h4142_0000_0000_0000, 10'd1000, 1'b1, 1, 16'd5});
      foreach (table_rows[i]) begin
         if (table_rows[i].chk) typed_roll.push_back(table_rows[i].x_roll);
         r = '{table_rows[i].roll, table_rows[i].name, table_rows[i].score,
               table_rows[i].last, 1'b0};
         send(r);
      end
      start <= 1'b0;
      drain();
      // Ascending roll with overflow: equal roll keys keep their load order.
      for (int i = 0; i < CAPACITY + 2; i++) begin
         r = '{16'(i % 3), 64'(i), 10'(i), i == CAPACITY + 1, 1'b0};
         send(r);
      end
      start <= 1'b0;
      drain();

      // Random sets across all key settings, extremes of direction included.
      n_set = 0;
      while (n_set < RAND_ITEMS) begin
         start <= 1'b0;
         drain();
         write_reg(REG_SORT_KEY, 2'($urandom_range(0, 3)));
         write_reg(REG_DESCENDING, 2'($urandom_range(0, 1)));
         begin
            int sz;
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
            for (int i = 0; i < sz; i++) begin
               r.roll  = ($urandom_range(0, 1)) ? 16'($urandom_range(0, 4)) : 16'($urandom);
               r.name  = rand_name();
               r.score = ($urandom_range(0, 4) == 0) ? 10'($urandom)
                                                     : 10'($urandom_range(0, 3) * 250);
               r.last  = (i == sz - 1);
               r.ovf   = 1'b0;
               send(r);
               n_set++;
            end
         end
      end
      start <= 1'b0;
      drain();

      if (n_errors == 0) $display("record_sort_by_selectable_key test passed");
      else $display("record_sort_by_selectable_key test failed");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/sbk_pkg.sv
rtl/core/sbk_datapath.sv
rtl/core/sbk_controller.sv
rtl/core/record_sort_by_selectable_key.sv
rtl/core/sbk_checker.sv
tb/record_sort_by_selectable_key_test.sv
